// File: sv/wfd_pkg.sv
// ----------------------------------------------------------------------------
// wfd_pkg
// Shared types and constants for the frame deframer.
// ----------------------------------------------------------------------------
package wfd_pkg;

  localparam int LEN_W           = 63;
  localparam int MAX_W           = 20;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [MAX_W-1:0] MAX_RESET = 20'd2047;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [3:0] EXT_SHORT  = 4'd2;
  localparam logic [3:0] EXT_LONG   = 4'd8;

  localparam logic KIND_HDR  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef enum logic [4:0] {
    PH_HDR1    = 5'b00001,
    PH_HDR2    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_MASK    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  // one queued result; data byte is unmasked in the back end
  typedef struct packed {
    logic             kind;
    logic [3:0]       opcode;
    logic             fin;
    logic             masked;
    logic [LEN_W-1:0] length;
    logic             too_long;
    logic [7:0]       raw;
    logic [7:0]       key;
    logic             last;
  } rec_t;

endpackage

// File: sv/wfd_front.sv
// ----------------------------------------------------------------------------
// wfd_front
// Header parser: tracks frame phase per byte and queues result records.
// ----------------------------------------------------------------------------
module wfd_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_rx_byte,
  input  logic                      in_restart,
  input  logic [wfd_pkg::MAX_W-1:0] max_len,
  output logic                      q_push,
  input  logic                      q_ready,
  output wfd_pkg::rec_t             q_rec
);
  import wfd_pkg::*;

  phase_t           phase_r,    phase_nxt;
  logic [3:0]       ext_left_r, ext_left_nxt;
  logic [LEN_W-1:0] len_r,      len_nxt;
  logic [LEN_W-1:0] remain_r,   remain_nxt;
  logic [31:0]      key_r,      key_nxt;
  logic [1:0]       key_cnt_r,  key_cnt_nxt;
  logic [1:0]       idx_r,      idx_nxt;
  logic             masked_r,   masked_nxt;
  logic [3:0]       opcode_r,   opcode_nxt;
  logic             fin_r,      fin_nxt;
  logic             discard_r,  discard_nxt;

  logic             accept;
  logic             emit;
  logic             finish;
  logic             too_long;
  logic             empty;
  logic             last_byte;
  logic [7:0]       kb;
  phase_t           cur_phase;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && emit;

  assign cur_phase = in_restart ? PH_HDR1 : phase_r;
  assign too_long  = (|len_nxt[LEN_W-1:MAX_W]) || (len_nxt[MAX_W-1:0] > max_len);
  assign empty     = (len_nxt == '0);
  assign last_byte = (remain_r <= {{(LEN_W-1){1'b0}}, 1'b1});

  always_comb begin
    case (idx_r)
      2'd0:    kb = key_r[31:24];
      2'd1:    kb = key_r[23:16];
      2'd2:    kb = key_r[15:8];
      default: kb = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt    = cur_phase;
    ext_left_nxt = ext_left_r;
    len_nxt      = len_r;
    remain_nxt   = remain_r;
    key_nxt      = key_r;
    key_cnt_nxt  = key_cnt_r;
    idx_nxt      = idx_r;
    masked_nxt   = masked_r;
    opcode_nxt   = opcode_r;
    fin_nxt      = fin_r;
    discard_nxt  = in_restart ? 1'b0 : discard_r;
    finish       = 1'b0;
    emit         = 1'b0;

    unique case (cur_phase)
      PH_HDR1: begin
        fin_nxt      = in_rx_byte[7];
        opcode_nxt   = in_rx_byte[3:0];
        masked_nxt   = 1'b0;
        key_nxt      = '0;
        len_nxt      = '0;
        ext_left_nxt = '0;
        key_cnt_nxt  = '0;
        idx_nxt      = '0;
        discard_nxt  = 1'b0;
        phase_nxt    = PH_HDR2;
      end
      PH_HDR2: begin
        masked_nxt  = in_rx_byte[7];
        key_cnt_nxt = '0;
        if (in_rx_byte[6:0] == LEN7_EXT16 || in_rx_byte[6:0] == LEN7_EXT64) begin
          len_nxt      = '0;
          ext_left_nxt = (in_rx_byte[6:0] == LEN7_EXT16) ? EXT_SHORT : EXT_LONG;
          phase_nxt    = PH_EXTLEN;
        end else begin
          len_nxt = {{(LEN_W-7){1'b0}}, in_rx_byte[6:0]};
          if (in_rx_byte[7]) begin
            phase_nxt = PH_MASK;
          end else begin
            finish = 1'b1;
          end
        end
      end
      PH_EXTLEN: begin
        len_nxt      = {len_r[LEN_W-9:0], in_rx_byte};
        ext_left_nxt = ext_left_r - 4'd1;
        if (ext_left_r == 4'd1) begin
          if (masked_r) begin
            phase_nxt = PH_MASK;
          end else begin
            finish = 1'b1;
          end
        end
      end
      PH_MASK: begin
        key_nxt     = {key_r[23:0], in_rx_byte};
        key_cnt_nxt = key_cnt_r + 2'd1;
        if (key_cnt_r == 2'd3) begin
          finish = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        idx_nxt    = idx_r + 2'd1;
        remain_nxt = remain_r - {{(LEN_W-1){1'b0}}, 1'b1};
        if (last_byte) begin
          phase_nxt   = PH_HDR1;
          discard_nxt = 1'b0;
        end
        emit = !discard_r;
      end
      default: begin
        phase_nxt = PH_HDR1;
      end
    endcase

    if (finish) begin
      emit        = 1'b1;
      remain_nxt  = len_nxt;
      idx_nxt     = '0;
      discard_nxt = too_long;
      phase_nxt   = empty ? PH_HDR1 : PH_PAYLOAD;
    end
  end

  always_comb begin
    q_rec.opcode = opcode_r;
    q_rec.fin    = fin_r;
    q_rec.masked = masked_nxt;
    if (cur_phase == PH_PAYLOAD) begin
      q_rec.kind     = KIND_DATA;
      q_rec.length   = len_r;
      q_rec.too_long = 1'b0;
      q_rec.raw      = in_rx_byte;
      q_rec.key      = kb;
      q_rec.last     = last_byte;
    end else begin
      q_rec.kind     = KIND_HDR;
      q_rec.length   = len_nxt;
      q_rec.too_long = too_long;
      q_rec.raw      = '0;
      q_rec.key      = '0;
      q_rec.last     = empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR1;
      ext_left_r <= '0;
      len_r      <= '0;
      remain_r   <= '0;
      key_r      <= '0;
      key_cnt_r  <= '0;
      idx_r      <= '0;
      masked_r   <= 1'b0;
      opcode_r   <= '0;
      fin_r      <= 1'b0;
      discard_r  <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      ext_left_r <= ext_left_nxt;
      len_r      <= len_nxt;
      remain_r   <= remain_nxt;
      key_r      <= key_nxt;
      key_cnt_r  <= key_cnt_nxt;
      idx_r      <= idx_nxt;
      masked_r   <= masked_nxt;
      opcode_r   <= opcode_nxt;
      fin_r      <= fin_nxt;
      discard_r  <= discard_nxt;
    end
  end

endmodule

// File: sv/wfd_queue.sv
// ----------------------------------------------------------------------------
// wfd_queue
// Small register FIFO of result records between parser and output stage.
// ----------------------------------------------------------------------------
module wfd_queue #(
  parameter int DEPTH = wfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          push_ready,
  input  wfd_pkg::rec_t push_rec,
  input  logic          pop,
  output logic          pop_valid,
  output wfd_pkg::rec_t pop_rec
);
  import wfd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rec_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_rec    = entry_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: sv/wfd_back.sv
// ----------------------------------------------------------------------------
// wfd_back
// Output stage: unmasks payload bytes and holds the result register.
// ----------------------------------------------------------------------------
module wfd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  wfd_pkg::rec_t             q_rec,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_kind,
  output logic [3:0]                out_frame_opcode,
  output logic                      out_final_fragment,
  output logic                      out_was_masked,
  output logic [wfd_pkg::LEN_W-1:0] out_payload_length,
  output logic                      out_too_long,
  output logic [7:0]                out_data_byte,
  output logic                      out_last_of_frame
);
  import wfd_pkg::*;

  logic             valid_r;
  logic             kind_r;
  logic [3:0]       opcode_r;
  logic             fin_r;
  logic             masked_r;
  logic [LEN_W-1:0] length_r;
  logic             too_long_r;
  logic [7:0]       data_r;
  logic             last_r;
  logic             load;

  assign load  = !valid_r || out_ready;
  assign q_pop = load && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r     <= q_rec.kind;
      opcode_r   <= q_rec.opcode;
      fin_r      <= q_rec.fin;
      masked_r   <= q_rec.masked;
      length_r   <= q_rec.length;
      too_long_r <= q_rec.too_long;
      data_r     <= q_rec.raw ^ q_rec.key;
      last_r     <= q_rec.last;
    end
  end

  assign out_valid          = valid_r;
  assign out_kind           = kind_r;
  assign out_frame_opcode   = opcode_r;
  assign out_final_fragment = fin_r;
  assign out_was_masked     = masked_r;
  assign out_payload_length = length_r;
  assign out_too_long       = too_long_r;
  assign out_data_byte      = data_r;
  assign out_last_of_frame  = last_r;

endmodule

// File: sv/websocket_frame_deframer_unit.sv
// One received byte per clock sustained; no stall while the output is taken.
// A result is written into the record queue and then into the output register.
// Throughput is set by the byte-wide parser; the record queue (QUEUE_DEPTH
// entries) and the output register absorb output back-pressure.
// Synchronous active-low reset: parser returns to first header byte, queue and
// output empty, payload length limit back to 2047.
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Byte-serial frame deframer: header parser, record queue, output stage.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit #(
  parameter int QUEUE_DEPTH = wfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_rx_byte,
  input  logic                      in_restart,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_kind,
  output logic [3:0]                out_frame_opcode,
  output logic                      out_final_fragment,
  output logic                      out_was_masked,
  output logic [wfd_pkg::LEN_W-1:0] out_payload_length,
  output logic                      out_too_long,
  output logic [7:0]                out_data_byte,
  output logic                      out_last_of_frame,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [wfd_pkg::MAX_W-1:0] cfg_max_payload_length
);
  import wfd_pkg::*;

  logic [MAX_W-1:0] max_len_r;
  logic             q_push;
  logic             q_push_ready;
  rec_t             q_in_rec;
  logic             q_pop;
  logic             q_pop_valid;
  rec_t             q_out_rec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_max_payload_length;
    end
  end

  wfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .in_restart (in_restart),
    .max_len    (max_len_r),
    .q_push     (q_push),
    .q_ready    (q_push_ready),
    .q_rec      (q_in_rec)
  );

  wfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_push_ready),
    .push_rec   (q_in_rec),
    .pop        (q_pop),
    .pop_valid  (q_pop_valid),
    .pop_rec    (q_out_rec)
  );

  wfd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_pop_valid),
    .q_pop              (q_pop),
    .q_rec              (q_out_rec),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_frame_opcode   (out_frame_opcode),
    .out_final_fragment (out_final_fragment),
    .out_was_masked     (out_was_masked),
    .out_payload_length (out_payload_length),
    .out_too_long       (out_too_long),
    .out_data_byte      (out_data_byte),
    .out_last_of_frame  (out_last_of_frame)
  );

endmodule
